FILE: sv/rwlq_pkg.sv
// Shared types and codes of the reader-writer lock queue unit.
// Used by rwlq_mem, rwlq_out and reader_writer_lock_queue_unit.
package rwlq_pkg;

    localparam int unsigned ID_W    = 16;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned TMO_W   = 16;
    localparam logic [15:0] READER_MAX = 16'hFFFF;
    localparam logic [15:0] TMO_RESET  = 16'd30;

    typedef enum logic [2:0] {
        OP_RDLOCK = 3'd0,
        OP_WRLOCK = 3'd1,
        OP_TRYRD  = 3'd2,
        OP_TRYWR  = 3'd3,
        OP_UNLOCK = 3'd4,
        OP_TICK   = 3'd5,
        OP_FLUSH  = 3'd6,
        OP_NONE   = 3'd7
    } t_op;

    typedef enum logic [3:0] {
        ST_GRANTED    = 4'd0,
        ST_QUEUED     = 4'd1,
        ST_BUSY       = 4'd2,
        ST_WGRANT     = 4'd3,
        ST_TIMEOUT    = 4'd4,
        ST_FLUSHED    = 4'd5,
        ST_DONE       = 4'd6,
        ST_FULL       = 4'd7,
        ST_UNLOCK_ERR = 4'd8
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SH_RD,
        S_SH_WR,
        S_INS,
        S_F_RD,
        S_F_EV,
        S_F_END,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        M_UNLOCK,
        M_TICK_GRANT,
        M_TICK_AGE,
        M_FLUSH
    } t_mode;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic               is_write;
        logic               prio;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef struct packed {
        logic            last;
        t_status         status;
        logic [ID_W-1:0] task_id;
    } t_res;

endpackage

FILE: sv/rwlq_mem.sv
// Waiter store: one write port, one registered read port.
// Depends on rwlq_pkg for the entry type.
module rwlq_mem
    import rwlq_pkg::*;
#(
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_entry                   i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_entry                   o_rdata
);
    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: sv/rwlq_out.sv
// Result output register on the master side of the stream.
// Depends on rwlq_pkg for the result type.
module rwlq_out
    import rwlq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_res        i_res,
    output logic        o_free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // task_id[15:0], status[19:16], zero fill
    output logic        m_tlast
);
    logic r_valid;
    t_res r_res;

    assign o_free = !r_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
        if (o_free && i_push) begin
            r_res <= i_res;
        end
    end

    assign m_tvalid = r_valid;
    assign m_tdata  = {4'd0, r_res.status, r_res.task_id};
    assign m_tlast  = r_res.last;
endmodule

FILE: sv/reader_writer_lock_queue_unit.sv
// Top level of the reader-writer lock queue unit: sequencer, holder state.
// Depends on rwlq_pkg, rwlq_mem and rwlq_out.
//
//  channel  | direction | signals
//  s_*      | in        | operation on tuser; requester, priority_req, now on tdata
//  m_*      | out       | task_id, status on tdata; last on tlast
//  cfg      | in        | wait_timeout write, always ready
//
// Lock and try ops pass decide and emit; queuing adds an insert, plus a read and a write step per waiter moved.
// Unlock, tick and flush visit each waiter per pass with a read step and an evaluate
// step; tick runs a grant pass, then an age pass if waiters remain, none if a writer holds.
// No clearing pass after reset. Output stalls hold the sequencer in place.
module reader_writer_lock_queue_unit
    import rwlq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // requester[15:0], priority_req[16], now[48:17], zero fill
    input  logic [2:0]  s_tuser,   // operation[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // task_id[15:0], status[19:16], zero fill
    output logic        m_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);
    localparam int unsigned IW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;
    logic   r_held, n_held;
    logic [ID_W-1:0] r_owner, n_owner;
    logic [15:0] r_rc, n_rc;
    logic [CW-1:0] r_cnt, n_cnt, r_pri, n_pri;
    logic [CW-1:0] r_i, n_i, r_keep, n_keep, r_pos, n_pos;
    logic r_granting, n_granting;
    t_status r_fin, n_fin;
    t_op r_op;
    logic [ID_W-1:0] r_req;
    logic r_prio;
    logic [STAMP_W-1:0] r_now;
    logic [TMO_W-1:0] r_tmo;

    logic we;
    logic [IW-1:0] waddr, raddr;
    t_entry wdata, e;
    logic push, ofree;
    t_res res;
    logic can_rd, can_wr, drop;
    t_status dstat;
    logic [STAMP_W-1:0] age;

    assign o_cfg_ready = 1'b1;
    assign s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tmo <= TMO_RESET;
        end else if (i_cfg_valid) begin
            r_tmo <= i_cfg_data;
        end
        if (s_tvalid && s_tready) begin
            r_op   <= t_op'(s_tuser);
            r_req  <= s_tdata[15:0];
            r_prio <= s_tdata[16];
            r_now  <= s_tdata[48:17];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_UNLOCK;
            r_held  <= 1'b0;
            r_owner <= '0;
            r_rc    <= '0;
            r_cnt   <= '0;
            r_pri   <= '0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_held  <= n_held;
            r_owner <= n_owner;
            r_rc    <= n_rc;
            r_cnt   <= n_cnt;
            r_pri   <= n_pri;
        end
        r_i        <= n_i;
        r_keep     <= n_keep;
        r_pos      <= n_pos;
        r_granting <= n_granting;
        r_fin      <= n_fin;
    end

    rwlq_mem #(.DEPTH(QUEUE_DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (e)
    );

    rwlq_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_res    (res),
        .o_free   (ofree),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    assign can_rd = !r_held && (r_rc != READER_MAX);
    assign can_wr = !r_held && (r_rc == 16'd0);
    assign age    = r_now - e.stamp;
    assign raddr  = (r_state == S_SH_RD || r_state == S_SH_WR) ?
                    IW'(r_i - CW'(1)) : IW'(r_i);

    always_comb begin
        drop  = 1'b0;
        dstat = ST_DONE;
        unique case (r_mode)
            M_UNLOCK: begin
                drop  = r_granting && (e.is_write ? can_wr : can_rd);
                dstat = ST_WGRANT;
            end
            M_TICK_GRANT: begin
                drop  = r_granting && !e.is_write && can_rd;
                dstat = ST_WGRANT;
            end
            M_TICK_AGE: begin
                drop  = age >= {16'd0, r_tmo};
                dstat = ST_TIMEOUT;
            end
            M_FLUSH: begin
                drop  = 1'b1;
                dstat = ST_FLUSHED;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_mode = r_mode;
        n_held = r_held;
        n_owner = r_owner;
        n_rc = r_rc;
        n_cnt = r_cnt;
        n_pri = r_pri;
        n_i = r_i;
        n_keep = r_keep;
        n_pos = r_pos;
        n_granting = r_granting;
        n_fin = r_fin;
        we = 1'b0;
        waddr = IW'(r_i);
        wdata = e;
        push = 1'b0;
        res = '{last: 1'b1, status: r_fin, task_id: r_req};
        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_EMIT;
                n_i = '0;
                n_keep = '0;
                n_granting = 1'b1;
                unique case (r_op)
                    OP_RDLOCK, OP_TRYRD: begin
                        if (can_rd && r_cnt == '0) begin
                            n_rc = r_rc + 16'd1;
                            n_fin = ST_GRANTED;
                        end else if (r_op == OP_TRYRD) begin
                            n_fin = ST_BUSY;
                        end else if (r_cnt >= DEPTH_C) begin
                            n_fin = ST_FULL;
                        end else begin
                            n_pos = r_cnt;
                            n_i = r_cnt;
                            n_state = S_INS;
                        end
                    end
                    OP_WRLOCK, OP_TRYWR: begin
                        if (can_wr) begin
                            n_held = 1'b1;
                            n_owner = r_req;
                            n_fin = ST_GRANTED;
                        end else if (r_op == OP_TRYWR) begin
                            n_fin = ST_BUSY;
                        end else if (r_cnt >= DEPTH_C) begin
                            n_fin = ST_FULL;
                        end else begin
                            n_pos = r_prio ? r_pri : r_cnt;
                            n_i = r_cnt;
                            n_state = (r_prio && r_pri != r_cnt) ? S_SH_RD : S_INS;
                        end
                    end
                    OP_UNLOCK: begin
                        n_fin = ST_DONE;
                        n_mode = M_UNLOCK;
                        n_state = S_F_END;
                        if (r_held) begin
                            n_held = 1'b0;
                        end else if (r_rc != 16'd0) begin
                            n_rc = r_rc - 16'd1;
                        end else begin
                            n_fin = ST_UNLOCK_ERR;
                            n_state = S_EMIT;
                        end
                        if (n_state == S_F_END && r_cnt != '0) begin
                            n_state = S_F_RD;
                        end
                    end
                    OP_TICK: begin
                        n_fin = ST_DONE;
                        n_mode = M_TICK_GRANT;
                        if (!r_held) begin
                            n_state = (r_cnt != '0) ? S_F_RD : S_F_END;
                        end
                    end
                    OP_FLUSH: begin
                        n_fin = ST_DONE;
                        n_mode = M_FLUSH;
                        n_state = (r_cnt != '0) ? S_F_RD : S_F_END;
                    end
                    default: begin
                        n_fin = ST_DONE;
                    end
                endcase
            end
            S_SH_RD: begin
                n_state = S_SH_WR;
            end
            S_SH_WR: begin
                we = 1'b1;
                waddr = IW'(r_i);
                n_i = r_i - CW'(1);
                n_state = (n_i == r_pos) ? S_INS : S_SH_RD;
            end
            S_INS: begin
                we = 1'b1;
                waddr = IW'(r_pos);
                wdata = '{id: r_req, is_write: (r_op == OP_WRLOCK),
                          prio: (r_op == OP_WRLOCK) && r_prio, stamp: r_now};
                n_cnt = r_cnt + CW'(1);
                if (r_op == OP_WRLOCK && r_prio) begin
                    n_pri = r_pri + CW'(1);
                end
                n_fin = ST_QUEUED;
                n_state = S_EMIT;
            end
            S_F_RD: begin
                n_state = S_F_EV;
            end
            S_F_EV: begin
                if (drop) begin
                    if (ofree) begin
                        push = 1'b1;
                        res = '{last: 1'b0, status: dstat, task_id: e.id};
                        if (e.prio) begin
                            n_pri = r_pri - CW'(1);
                        end
                        if (r_mode == M_UNLOCK && e.is_write) begin
                            n_held = 1'b1;
                            n_owner = e.id;
                        end else if (r_mode == M_UNLOCK || r_mode == M_TICK_GRANT) begin
                            n_rc = r_rc + 16'd1;
                        end
                    end
                end else begin
                    we = 1'b1;
                    waddr = IW'(r_keep);
                    n_keep = r_keep + CW'(1);
                    if (r_mode == M_UNLOCK || (r_mode == M_TICK_GRANT && !e.is_write)) begin
                        n_granting = 1'b0;
                    end
                end
                if (!drop || ofree) begin
                    n_i = r_i + CW'(1);
                    n_state = (n_i == r_cnt) ? S_F_END : S_F_RD;
                end
            end
            S_F_END: begin
                n_cnt = r_keep;
                n_i = '0;
                n_keep = '0;
                if (r_mode == M_TICK_GRANT && r_keep != '0) begin
                    n_mode = M_TICK_AGE;
                    n_state = S_F_RD;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (ofree) begin
                    push = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= DEPTH_C) else $error("waiter count beyond depth");
    a_pri_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pri <= r_cnt) else $error("priority prefix beyond waiter count");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> r_rc == 16'd0) else $error("writer and readers both hold");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready) else $error("beat taken while busy");
endmodule
